FILE: rtl/core/qea_pkg.sv
// ----------------------------------------------------------------------------
// qea_pkg
// shared types, codes and widths of the quadrature decoder with acceleration
// ----------------------------------------------------------------------------
package qea_pkg;

    localparam int NUM_W  = 56;
    localparam int DEN_W  = 48;
    localparam int PROD_W = 64;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_NEXT = 2'd1,
        EV_PREV = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        CFG_DETENT  = 3'd0,
        CFG_REVERSE = 3'd1,
        CFG_MAXSTEP = 3'd2,
        CFG_MAXTIME = 3'd3,
        CFG_MINTIME = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        event_t      ev;
        logic        accel;
        logic [31:0] now;
    } item_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

    function automatic logic signed [4:0] step_of(input logic [3:0] code);
        logic signed [4:0] s;
        case (code)
            4'd1, 4'd7, 4'd8, 4'd14:  s = 5'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: s = -5'sd1;
            default:                  s = 5'sd0;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/core/quadrature_encoder_accelerated_unit.sv
// ----------------------------------------------------------------------------
// quadrature_encoder_accelerated_unit
// quadrature decoder with detent events and speed-dependent step count
// ----------------------------------------------------------------------------
// channel   dir  signals                    transaction
// s_axis    in   s_tvalid/s_tready/s_tdata  one pin sample with timestamp
// m_axis    out  m_tvalid/m_tready/m_tdata  one result per sample
// cfg       in   cfg_we/cfg_addr/cfg_data   register write, no wait
//
// a sample with no event, or an event without acceleration, is answered straight from the idle state
// an event with zero interval is answered from the gap state
// an accelerated event passes through gap, history sum, average,
// five multiply steps and the 56-bit serial division of the step law
// a two-entry queue lets the decoder keep taking samples while the engine works
// a result held by the receiver stalls the engine; reset restores all defaults
// ----------------------------------------------------------------------------
module quadrature_encoder_accelerated_unit
#(
    parameter int HISTORY_DEPTH = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pin_a, pin_b, now_ms[31:0], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // event_res[1:0], repeat_steps[7:0], avg_interval_ms[15:0], pad
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    logic [2:0]     detent_reg;
    logic           reverse_reg;
    logic [7:0]     maxstep_reg;
    logic [15:0]    maxtime_reg, mintime_reg;
    logic           push, pop, q_full, q_empty;
    qea_pkg::item_t push_item, head;
    logic [1:0]     event_res;
    logic [7:0]     repeat_steps;
    logic [15:0]    avg_interval_ms;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detent_reg  <= 3'd4;
            reverse_reg <= 1'b0;
            maxstep_reg <= 8'd0;
            maxtime_reg <= 16'd200;
            mintime_reg <= 16'd30;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                qea_pkg::CFG_DETENT:  detent_reg  <= cfg_data[2:0];
                qea_pkg::CFG_REVERSE: reverse_reg <= cfg_data[0];
                qea_pkg::CFG_MAXSTEP: maxstep_reg <= cfg_data[7:0];
                qea_pkg::CFG_MAXTIME: maxtime_reg <= cfg_data;
                qea_pkg::CFG_MINTIME: mintime_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    qea_front u_front
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (s_tvalid),
        .pin_a              (s_tdata[0]),
        .pin_b              (s_tdata[1]),
        .now_ms             (s_tdata[33:2]),
        .q_full             (q_full),
        .detent_transitions (detent_reg),
        .reverse_direction  (reverse_reg),
        .max_extra_steps    (maxstep_reg),
        .in_ready           (s_tready),
        .push               (push),
        .push_item          (push_item)
    );

    qea_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head)
    );

    qea_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_empty            (q_empty),
        .head               (head),
        .pop                (pop),
        .max_extra_steps    (maxstep_reg),
        .max_repeat_time_ms (maxtime_reg),
        .min_repeat_time_ms (mintime_reg),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .event_res          (event_res),
        .repeat_steps       (repeat_steps),
        .avg_interval_ms    (avg_interval_ms)
    );

    assign m_tdata = {6'd0, avg_interval_ms, repeat_steps, event_res};

endmodule

FILE: rtl/core/qea_front.sv
// ----------------------------------------------------------------------------
// qea_front
// pin transition decode and detent counting, one sample per cycle while the queue is not full
// ----------------------------------------------------------------------------
module qea_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              pin_a,
    input  logic              pin_b,
    input  logic [31:0]       now_ms,
    input  logic              q_full,
    input  logic [2:0]        detent_transitions,
    input  logic              reverse_direction,
    input  logic [7:0]        max_extra_steps,
    output logic              in_ready,
    output logic              push,
    output qea_pkg::item_t    push_item
);

    logic [3:0]        hist_reg, hist_next;
    logic signed [4:0] cnt_reg, cnt_next;
    logic [1:0]        pins;
    logic signed [4:0] sum;
    logic signed [4:0] lim;
    qea_pkg::event_t   ev;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;
    assign pins     = {pin_a, pin_b};

    always_comb
    begin
        hist_next = hist_reg;
        cnt_next  = cnt_reg;
        ev        = qea_pkg::EV_NONE;
        lim       = (detent_transitions == 3'd0) ? 5'sd1 : $signed({2'b00, detent_transitions});
        sum       = cnt_reg;
        if (pins != hist_reg[1:0])
        begin
            hist_next = {hist_reg[1:0], pins};
            sum       = cnt_reg + qea_pkg::step_of(hist_next);
            cnt_next  = sum;
            if (sum >= lim)
            begin
                cnt_next = 5'sd0;
                ev = reverse_direction ? qea_pkg::EV_PREV : qea_pkg::EV_NEXT;
            end
            else if (sum <= -lim)
            begin
                cnt_next = 5'sd0;
                ev = reverse_direction ? qea_pkg::EV_NEXT : qea_pkg::EV_PREV;
            end
        end
        push_item.ev    = ev;
        push_item.accel = (max_extra_steps > 8'd1);
        push_item.now   = now_ms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= 4'd0;
            cnt_reg  <= 5'sd0;
        end
        else if (push)
        begin
            hist_reg <= hist_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

FILE: rtl/core/qea_queue.sv
// ----------------------------------------------------------------------------
// qea_queue
// two-entry queue between the decoder and the acceleration engine
// ----------------------------------------------------------------------------
module qea_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  qea_pkg::item_t  push_item,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output qea_pkg::item_t  head
);

    qea_pkg::item_t mem_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: rtl/core/qea_div.sv
// ----------------------------------------------------------------------------
// qea_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module qea_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  qea_pkg::div_req_t req,
    output qea_pkg::div_rsp_t rsp
);

    localparam int NW = qea_pkg::NUM_W;
    localparam int DW = qea_pkg::DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   shifted;
    logic [DW+1:0] diff;

    assign shifted  = {rem_reg[DW-1:0], q_reg[NW-1]};
    assign diff     = {1'b0, shifted} - {2'b00, den_reg};
    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[DW+1])
            begin
                rem_reg <= diff[DW:0];
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

endmodule

FILE: rtl/core/qea_back.sv
// ----------------------------------------------------------------------------
// qea_back
// interval history, averaging and cubic step law, with output register
// ----------------------------------------------------------------------------
module qea_back
#(
    parameter int HISTORY_DEPTH = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  qea_pkg::item_t    head,
    output logic              pop,
    input  logic [7:0]        max_extra_steps,
    input  logic [15:0]       max_repeat_time_ms,
    input  logic [15:0]       min_repeat_time_ms,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        event_res,
    output logic [7:0]        repeat_steps,
    output logic [15:0]       avg_interval_ms
);

    localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SW = 16 + $clog2(HISTORY_DEPTH + 1);
    localparam int LW = $clog2(HISTORY_DEPTH);
    localparam int RW = SW + LW;
    // reciprocal of the history depth, exact for every sum below 2^SW
    localparam logic [63:0] RECIP = ((64'd1 << RW) + 64'(HISTORY_DEPTH - 1))
                                    / 64'(HISTORY_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_GAP, S_SUM, S_AVG, S_M1, S_M2, S_M3, S_M4, S_M5, S_DIV
    } state_t;

    state_t                   state_reg;
    logic [15:0]              store_reg [HISTORY_DEPTH];
    logic [IW-1:0]            idx_reg, cnt_reg, idx_inc;
    logic [31:0]              last_reg, now_reg;
    logic [15:0]              avg_reg, dt_reg, dif_reg;
    logic [SW-1:0]            sum_reg;
    logic [qea_pkg::PROD_W-1:0] prod_reg;
    logic [qea_pkg::NUM_W-1:0]  num_reg;
    logic [qea_pkg::DEN_W-1:0]  den_reg;
    qea_pkg::event_t          ev_reg;
    logic                     out_valid_reg;
    logic [7:0]               steps_reg;
    logic [47:0]              mul_x;
    logic [15:0]              mul_y;
    logic [qea_pkg::PROD_W-1:0] prod;
    logic [31:0]              gap;
    logic [15:0]              gap_c;
    logic                     slot_free;
    qea_pkg::div_req_t        dreq;
    qea_pkg::div_rsp_t        drsp;
    logic [2*SW:0]            avg_prod;
    logic [15:0]              q_avg;

    qea_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign slot_free       = !out_valid_reg || out_ready;
    assign pop             = (state_reg == S_IDLE) && !q_empty && slot_free;
    assign out_valid       = out_valid_reg;
    assign event_res       = ev_reg;
    assign repeat_steps    = steps_reg;
    assign avg_interval_ms = avg_reg;
    assign gap             = now_reg - last_reg;
    assign idx_inc         = (idx_reg >= IW'(HISTORY_DEPTH - 1)) ? '0 : idx_reg + 1'b1;
    assign avg_prod        = sum_reg * RECIP[SW:0];
    assign q_avg           = avg_prod[RW+15:RW];
    assign prod            = mul_x * mul_y;

    always_comb
    begin
        if (gap > {16'd0, max_repeat_time_ms})
            gap_c = max_repeat_time_ms;
        else if (gap < {16'd0, min_repeat_time_ms})
            gap_c = min_repeat_time_ms;
        else
            gap_c = gap[15:0];
    end

    always_comb
    begin
        case (state_reg)
            S_M1:    begin mul_x = {32'd0, dt_reg};   mul_y = dt_reg;  end
            S_M2:    begin mul_x = prod_reg[47:0];    mul_y = dt_reg;  end
            S_M3:    begin mul_x = prod_reg[47:0];    mul_y = {8'd0, max_extra_steps}; end
            S_M4:    begin mul_x = {32'd0, dif_reg};  mul_y = dif_reg; end
            S_M5:    begin mul_x = prod_reg[47:0];    mul_y = dif_reg; end
            default: begin mul_x = '0;                mul_y = '0;      end
        endcase
    end

    always_comb
    begin
        dreq.start = 1'b0;
        dreq.num   = num_reg;
        dreq.den   = den_reg;
        if (state_reg == S_M5)
        begin
            dreq.start = 1'b1;
            dreq.den   = prod[qea_pkg::DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            last_reg      <= 32'd0;
            avg_reg       <= 16'd0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                store_reg[i] <= 16'd0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        ev_reg  <= head.ev;
                        now_reg <= head.now;
                        if (head.ev == qea_pkg::EV_NONE || !head.accel)
                        begin
                            out_valid_reg <= 1'b1;
                            steps_reg <= (head.ev == qea_pkg::EV_NONE) ? 8'd0 : 8'd1;
                        end
                        else
                            state_reg <= S_GAP;
                    end
                end
                S_GAP:
                begin
                    last_reg <= now_reg;
                    if (gap == 32'd0)
                    begin
                        out_valid_reg <= 1'b1;
                        steps_reg     <= 8'd1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        // a long gap refills the whole history with the maximum
                        if (gap > {16'd0, max_repeat_time_ms})
                        begin
                            for (int i = 0; i < HISTORY_DEPTH; i++)
                                store_reg[i] <= max_repeat_time_ms;
                        end
                        else
                            store_reg[idx_inc] <= gap_c;
                        idx_reg   <= idx_inc;
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    sum_reg <= sum_reg + {{(SW-16){1'b0}}, store_reg[cnt_reg]};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == IW'(HISTORY_DEPTH - 1))
                        state_reg <= S_AVG;
                end
                S_AVG:
                begin
                    avg_reg <= q_avg;
                    dt_reg  <= max_repeat_time_ms - q_avg;
                    dif_reg <= max_repeat_time_ms - min_repeat_time_ms;
                    if (q_avg < max_repeat_time_ms && min_repeat_time_ms < max_repeat_time_ms)
                        state_reg <= S_M1;
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        steps_reg     <= 8'd1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_M1:
                begin
                    prod_reg  <= prod;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    prod_reg  <= prod;
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    num_reg   <= prod[qea_pkg::NUM_W-1:0];
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    prod_reg  <= prod;
                    state_reg <= S_M5;
                end
                S_M5:
                begin
                    den_reg   <= prod[qea_pkg::DEN_W-1:0];
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (drsp.done)
                    begin
                        out_valid_reg <= 1'b1;
                        if (drsp.quot >= qea_pkg::NUM_W'(max_extra_steps))
                            steps_reg <= max_extra_steps;
                        else
                            steps_reg <= drsp.quot[7:0] + 8'd1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the quadrature decoder with acceleration against a behavioral
// predictor: directed pin sequences per register setting, random rotation
// bursts with random timing, long output back-pressure, random idle on both
// stream sides
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH = 12;
    localparam int SETTLE = 300;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // pin_a, pin_b, now_ms[31:0], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // event_res[1:0], repeat_steps[7:0], avg_interval_ms[15:0], pad
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_data;

    typedef struct packed {
        logic [1:0]  ev;
        logic [7:0]  steps;
        logic [15:0] avg;
    } decode_t;

    // predictor state
    logic [2:0]  detent_cfg;
    logic        reverse_cfg;
    logic [7:0]  maxstep_cfg;
    logic [15:0] maxtime_cfg;
    logic [15:0] mintime_cfg;
    logic [3:0]  pins_hist;
    int          detents;
    logic [31:0] last_time;
    logic [15:0] intervals [DEPTH];
    int          ring_pos;
    logic [15:0] avg_gap;

    decode_t expected_q [$];
    int      errors;
    int      sent;
    int      got;
    int      events_seen;
    int      send_idle_pct;
    int      recv_idle_pct;
    bit      hold_off;
    logic [31:0] clock_ms;
    logic    pa;
    logic    pb;

    quadrature_encoder_accelerated_unit DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("timeout");
        $display("FAILURE");
        $finish;
    end

    task automatic report(input string what, input int got_v, input int exp_v);
        errors++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got_v, exp_v, got);
    endtask

    function automatic logic signed [1:0] trans_step(input logic [3:0] code);
        case (code)
            4'd1, 4'd7, 4'd8, 4'd14:  return 2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: return -2'sd1;
            default:                  return 2'sd0;
        endcase
    endfunction

    function automatic logic [7:0] accel_steps(input logic [31:0] now);
        logic [31:0] gap;
        logic [31:0] total;
        logic [63:0] dt;
        logic [63:0] dif;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        gap = now - last_time;
        last_time = now;
        if (gap == 0)
            return 8'd1;
        if (gap > {16'd0, maxtime_cfg})
        begin
            foreach (intervals[i])
                intervals[i] = maxtime_cfg;
            gap = {16'd0, maxtime_cfg};
        end
        else if (gap < {16'd0, mintime_cfg})
            gap = {16'd0, mintime_cfg};
        ring_pos = (ring_pos + 1 >= DEPTH) ? 0 : ring_pos + 1;
        intervals[ring_pos] = gap[15:0];
        total = 0;
        foreach (intervals[i])
            total += {16'd0, intervals[i]};
        avg_gap = 16'(total / DEPTH);
        if (avg_gap < maxtime_cfg && mintime_cfg < maxtime_cfg)
        begin
            dt = maxtime_cfg - avg_gap;
            dif = maxtime_cfg - mintime_cfg;
            num = maxstep_cfg * dt * dt * dt;
            den = dif * dif * dif;
            q = num / den;
            if (q >= maxstep_cfg)
                return maxstep_cfg;
            return q[7:0] + 8'd1;
        end
        return 8'd1;
    endfunction

    function automatic decode_t predict_decode(input logic a, input logic b,
                                               input logic [31:0] now);
        decode_t r;
        logic [1:0] pins;
        int lim;
        pins = {a, b};
        lim = (detent_cfg == 3'd0) ? 1 : int'(detent_cfg);
        r = '0;
        if (pins != pins_hist[1:0])
        begin
            pins_hist = {pins_hist[1:0], pins};
            detents += trans_step(pins_hist);
            if (detents >= lim)
            begin
                detents = 0;
                r.ev = reverse_cfg ? qea_pkg::EV_PREV : qea_pkg::EV_NEXT;
            end
            else if (detents <= -lim)
            begin
                detents = 0;
                r.ev = reverse_cfg ? qea_pkg::EV_NEXT : qea_pkg::EV_PREV;
            end
            if (r.ev != qea_pkg::EV_NONE)
                r.steps = (maxstep_cfg > 8'd1) ? accel_steps(now) : 8'd1;
        end
        r.avg = avg_gap;
        return r;
    endfunction

    task automatic send_sample(input logic a, input logic b, input logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        expected_q.push_back(predict_decode(a, b, now));
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, now, b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    // result checker and output stall
    always @(posedge clk)
    begin
        decode_t want;
        if (m_tvalid && m_tready)
        begin
            got++;
            if (expected_q.size() == 0)
                report("unexpected result", m_tdata[1:0], -1);
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata[1:0] != want.ev)
                    report("event_res", m_tdata[1:0], want.ev);
                if (m_tdata[9:2] != want.steps)
                    report("repeat_steps", m_tdata[9:2], want.steps);
                if (m_tdata[25:10] != want.avg)
                    report("avg_interval_ms", m_tdata[25:10], want.avg);
                if (want.ev != qea_pkg::EV_NONE)
                    events_seen++;
            end
        end
        m_tready <= rst_n && !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    task automatic write_reg(input qea_pkg::cfg_idx_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            qea_pkg::CFG_DETENT:  detent_cfg = val[2:0];
            qea_pkg::CFG_REVERSE: reverse_cfg = val[0];
            qea_pkg::CFG_MAXSTEP: maxstep_cfg = val[7:0];
            qea_pkg::CFG_MAXTIME: maxtime_cfg = val;
            qea_pkg::CFG_MINTIME: mintime_cfg = val;
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [2:0] det, input logic rev, input logic [7:0] mx,
                           input logic [15:0] tmax, input logic [15:0] tmin);
        drain();
        write_reg(qea_pkg::CFG_DETENT, {13'd0, det});
        write_reg(qea_pkg::CFG_REVERSE, {15'd0, rev});
        write_reg(qea_pkg::CFG_MAXSTEP, {8'd0, mx});
        write_reg(qea_pkg::CFG_MAXTIME, tmax);
        write_reg(qea_pkg::CFG_MINTIME, tmin);
        cfg_we <= 1'b0;
    endtask

    // one gray-code step forward or backward
    task automatic rotate(input bit fwd, input int dt_ms);
        logic [1:0] g;
        g = {pa, pb};
        case (g)
            2'b00: g = fwd ? 2'b01 : 2'b10;
            2'b01: g = fwd ? 2'b11 : 2'b00;
            2'b11: g = fwd ? 2'b10 : 2'b01;
            default: g = fwd ? 2'b00 : 2'b11;
        endcase
        {pa, pb} = g;
        clock_ms += dt_ms;
        send_sample(pa, pb, clock_ms);
    endtask

    task automatic test_directed();
        send_sample(1'b0, 1'b0, 32'd0);
        for (int i = 0; i < 8; i++)
            rotate(1'b1, 10);
        for (int i = 0; i < 8; i++)
            rotate(1'b0, 0);
        send_sample(1'b1, 1'b1, 32'hFFFF_FFFF);
        send_sample(1'b0, 1'b0, 32'h0000_0005);
        {pa, pb} = 2'b00;
        clock_ms = 32'hFFFF_FFF0;
        for (int i = 0; i < 6; i++)
            rotate(1'b1, 20);
    endtask

    task automatic test_settings();
        set_all(3'd1, 1'b1, 8'd255, 16'd200, 16'd30);
        for (int i = 0; i < 10; i++) rotate(1'b1, 5);
        for (int i = 0; i < 4; i++) rotate(1'b1, 0);
        rotate(1'b0, 500);
        set_all(3'd0, 1'b0, 8'd1, 16'd65535, 16'd0);
        for (int i = 0; i < 5; i++) rotate(1'b1, 3);
        set_all(3'd2, 1'b0, 8'd200, 16'd100, 16'd100);
        for (int i = 0; i < 6; i++) rotate(1'b0, 7);
        set_all(3'd7, 1'b1, 8'd255, 16'd65535, 16'd0);
        for (int i = 0; i < 16; i++) rotate(1'b1, 1);
        for (int i = 0; i < 3; i++) rotate(1'b1, 2);
        // lower the threshold while the counter is part way
        drain();
        write_reg(qea_pkg::CFG_DETENT, 16'd1);
        cfg_we <= 1'b0;
        rotate(1'b1, 4);
        set_all(3'd4, 1'b0, 8'd2, 16'd0, 16'd65535);
        for (int i = 0; i < 6; i++) rotate(1'b0, 9);
    endtask

    task automatic test_backpressure();
        set_all(3'd1, 1'b0, 8'd100, 16'd300, 16'd10);
        hold_off = 1'b1;
        fork
            begin
                repeat (2000) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 30; i++) rotate(1'b1, 15);
        join
    endtask

    task automatic test_random(input int count);
        int n;
        bit fwd;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                set_all(3'($urandom_range(7)), 1'($urandom_range(1)),
                        8'($urandom_range(255)),
                        16'($urandom_range(3) == 0 ? $urandom : $urandom_range(400)),
                        16'($urandom_range(3) == 0 ? $urandom : $urandom_range(100)));
            end
            fwd = 1'($urandom_range(1));
            repeat ($urandom_range(1, 12))
            begin
                if ($urandom_range(9) == 0)
                begin
                    clock_ms += $urandom_range(1) ? $urandom : $urandom_range(50);
                    pa = 1'($urandom_range(1));
                    pb = 1'($urandom_range(1));
                    send_sample(pa, pb, clock_ms);
                end
                else
                    rotate($urandom_range(19) == 0 ? !fwd : fwd,
                           $urandom_range(3) == 0 ? $urandom_range(600) : $urandom_range(60));
                n++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = qea_pkg::CFG_DETENT;
        cfg_data = '0;
        hold_off = 1'b0;
        errors = 0;
        sent = 0;
        got = 0;
        events_seen = 0;
        detent_cfg = 3'd4;
        reverse_cfg = 1'b0;
        maxstep_cfg = 8'd0;
        maxtime_cfg = 16'd200;
        mintime_cfg = 16'd30;
        pins_hist = '0;
        detents = 0;
        last_time = '0;
        foreach (intervals[i])
            intervals[i] = '0;
        ring_pos = 0;
        avg_gap = '0;
        clock_ms = '0;
        pa = 1'b0;
        pb = 1'b0;
        send_idle_pct = 32;
        recv_idle_pct = 55;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_settings();
        test_backpressure();
        test_random(500);
        send_idle_pct = 55;
        recv_idle_pct = 32;
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(450);
        drain();
        $display("sent %0d samples, checked %0d results, %0d of them events",
                 sent, got, events_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
